[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the run queue.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/rrq_pkg.sv]
// Package for the round-robin run queue: widths, status codes and operation codes.
// No dependencies.
`default_nettype none
package rrq_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [15:0] DefaultTimeout = 16'd15;

  typedef enum logic [1:0] {
    FuncEnqueue = 2'd0,
    FuncSetRun  = 2'd1,
    FuncPick    = 2'd2,
    FuncExpire  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    StAccepted     = 4'd0,
    StAlready      = 4'd1,
    StFull         = 4'd2,
    StUpdated      = 4'd3,
    StNotFound     = 4'd4,
    StPicked       = 4'd5,
    StNoneReady    = 4'd6,
    StExpired      = 4'd7,
    StNoneExpired  = 4'd8
  } status_e;

  // One queue entry: task id, start minute, ready bit.
  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] start;
    logic        ready;
  } entry_t;
endpackage
`default_nettype wire

[hw/rtl/round_robin_ready_queue_with_expiry.sv]
// Round-robin run queue with expiry: one memory of entries, one sequencer.
// Each item scans the stored entries before its result; a pick that finds a task also
// shifts later entries down and writes it back at the tail. Expire holds each expired
// result back by one entry so the last is flagged; a consumer stall holds each result.
// Items: one at a time, taken after the last result transfer of the one before. Reset
// clears count, sequencer and timeout (15), not the memory.
`default_nettype none
`include "assert_macros.svh"
module round_robin_ready_queue_with_expiry import rrq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: func[1:0], task_id[17:2], runnable[18], now_minute[50:19], zero pad
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[3:0], result_task[19:4], zero pad
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SScan  = 7'b0000010,
    SShift = 7'b0000100,
    SWrite = 7'b0001000,
    SExp   = 7'b0010000,
    SOut   = 7'b0100000,
    SFin   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  entry_t mem [QueueDepth];
  entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;
  logic we;
  logic [IdxW-1:0] wr_addr;
  entry_t wr_data;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;   // one past the entry whose data arrives this cycle
  logic [CntW-1:0] keep_q, keep_d;
  logic [15:0] timeout_q;
  func_e func_q;
  logic [15:0] tid_q;
  logic run_q;
  logic [31:0] now_q;
  logic found_q, found_d;
  logic [IdxW-1:0] pos_q, pos_d;
  entry_t hold_q, hold_d;
  logic any_q, any_d;
  logic [3:0] ost_q, ost_d;
  logic [15:0] otask_q, otask_d;
  logic olast_q, olast_d;
  logic ovalid_q, ovalid_d;
  logic [31:0] age;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign cfg_ready_o = (state_q == SIdle) && !s_axis_tvalid;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= DefaultTimeout;
    else if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
  end

  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, otask_q, ost_q};
  assign m_axis_tlast  = olast_q;
  assign age = now_q - rd_q.start;

  // Data of entry idx_q-1 arrives in rd_q during scan states.
  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; keep_d = keep_q;
    found_d = found_q; pos_d = pos_q; hold_d = hold_q; any_d = any_q;
    ost_d = ost_q; otask_d = otask_q; olast_d = olast_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    rd_en = 1'b0; rd_addr = '0; we = 1'b0; wr_addr = '0; wr_data = hold_q;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          idx_d = '0; keep_d = '0; found_d = 1'b0; any_d = 1'b0;
          state_d = (func_e'(s_axis_tdata[1:0]) == FuncExpire) ? SExp : SScan;
          rd_en = 1'b1; rd_addr = '0;
          if (count_q == '0) state_d = SFin;
          else idx_d = CntW'(1);
        end
      end
      SScan: begin
        // rd_q holds entry idx_q-1
        if (!found_q) begin
          if ((func_q == FuncPick) ? rd_q.ready : (rd_q.task_id == tid_q)) begin
            found_d = 1'b1; pos_d = IdxW'(idx_q - CntW'(1)); hold_d = rd_q;
          end
        end
        if (found_d && func_q != FuncPick) begin
          state_d = SFin;
        end else if (found_d && func_q == FuncPick) begin
          // shift following entries down: read entry pos+1 onward
          if (idx_q < count_q) begin
            rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
            state_d = SShift;
          end else state_d = SWrite;
        end else if (idx_q < count_q) begin
          rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
        end else state_d = SFin;
      end
      SShift: begin
        we = 1'b1; wr_addr = IdxW'(idx_q - CntW'(2)); wr_data = rd_q;
        if (idx_q < count_q) begin
          rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
        end else state_d = SWrite;
      end
      SWrite: begin
        we = 1'b1; wr_addr = IdxW'(count_q - CntW'(1)); wr_data = hold_q;
        state_d = SFin;
      end
      SExp: begin
        // An expired entry is held in hold_q until the next one shows up, so the
        // final expired result can carry tlast.
        if (age >= {16'd0, timeout_q}) begin
          hold_d = rd_q; any_d = 1'b1;
          if (any_q) begin
            ost_d = StExpired; otask_d = hold_q.task_id;
            olast_d = 1'b0; ovalid_d = 1'b1;
            state_d = SOut;
          end else if (idx_q < count_q) begin
            rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
          end else state_d = SFin;
        end else begin
          we = 1'b1; wr_addr = keep_q[IdxW-1:0]; wr_data = rd_q;
          keep_d = keep_q + CntW'(1);
          if (idx_q < count_q) begin
            rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
          end else state_d = SFin;
        end
      end
      SOut: begin
        if (m_axis_tready) begin
          if (idx_q < count_q) begin
            rd_en = 1'b1; rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + CntW'(1);
            state_d = SExp;
          end else begin
            state_d = SFin;
          end
        end
      end
      SFin: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1; olast_d = 1'b1; otask_d = '0; state_d = SIdle;
          case (func_q)
            FuncEnqueue: begin
              if (found_q) ost_d = StAlready;
              else if (count_q == CntW'(QueueDepth)) ost_d = StFull;
              else begin
                ost_d = StAccepted; we = 1'b1; wr_addr = count_q[IdxW-1:0];
                wr_data = '{task_id: tid_q, start: now_q, ready: run_q};
                count_d = count_q + CntW'(1);
              end
            end
            FuncSetRun: begin
              if (found_q) begin
                ost_d = StUpdated; we = 1'b1; wr_addr = pos_q;
                wr_data = '{task_id: hold_q.task_id, start: hold_q.start, ready: run_q};
              end else ost_d = StNotFound;
            end
            FuncPick: begin
              ost_d = found_q ? StPicked : StNoneReady;
              otask_d = found_q ? hold_q.task_id : '0;
            end
            FuncExpire: begin
              count_d = keep_q;
              if (any_q) begin
                ost_d = StExpired; otask_d = hold_q.task_id;
              end else ost_d = StNoneExpired;
            end
            default: ;
          endcase
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; count_q <= '0; ovalid_q <= 1'b0;
      idx_q <= '0; keep_q <= '0; found_q <= 1'b0; any_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovalid_q <= ovalid_d;
      idx_q <= idx_d; keep_q <= keep_d; found_q <= found_d; any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; hold_q <= hold_d; ost_q <= ost_d; otask_q <= otask_d;
    olast_q <= olast_d;
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= func_e'(s_axis_tdata[1:0]); tid_q <= s_axis_tdata[17:2];
      run_q <= s_axis_tdata[18]; now_q <= s_axis_tdata[50:19];
    end
  end

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntW'(QueueDepth),
                "queue count above depth")
  `ASSERT_NEVER(a_keep_le_idx, clk_i, rst_ni, keep_q > idx_q, "keep pointer passed scan")
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
               (ovalid_q && !m_axis_tready) |=> ovalid_q, "result dropped while stalled")
  `ASSERT_NEVER(a_busy_no_accept, clk_i, rst_ni,
                s_axis_tready && state_q != SIdle, "accept while busy")

endmodule
`default_nettype wire
